FILE: rtl/jfss_pkg.sv
package jfss_pkg;

  // marker and segment constants
  localparam logic [7:0]  MARK_PREFIX = 8'hFF;
  localparam logic [7:0]  SOI_ID      = 8'hD8;
  localparam logic [7:0]  SOF0_ID     = 8'hC0;
  localparam logic [15:0] LEN_MIN     = 16'd2;
  localparam logic [15:0] SOF_SKIP    = 16'd3;

  // result status codes
  typedef enum logic [2:0] {
    ST_FOUND  = 3'd0,
    ST_BADSIG = 3'd1,
    ST_NOMARK = 3'd2,
    ST_ENDED  = 3'd3,
    ST_SHORT  = 3'd4
  } status_t;

  // parser phases, one-hot
  typedef enum logic [14:0] {
    PH_SIG0    = 15'b000000000000001,
    PH_SIG1    = 15'b000000000000010,
    PH_ID0     = 15'b000000000000100,
    PH_ID1     = 15'b000000000001000,
    PH_LEN_HI  = 15'b000000000010000,
    PH_LEN_LO  = 15'b000000000100000,
    PH_SKIP    = 15'b000000001000000,
    PH_MARK_FF = 15'b000000010000000,
    PH_MARK_ID = 15'b000000100000000,
    PH_SOF     = 15'b000001000000000,
    PH_H_HI    = 15'b000010000000000,
    PH_H_LO    = 15'b000100000000000,
    PH_W_HI    = 15'b001000000000000,
    PH_W_LO    = 15'b010000000000000,
    PH_ABSORB  = 15'b100000000000000
  } phase_t;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_stream;
  } item_t;

  // one result item
  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    status_t     status;
  } result_t;

endpackage

FILE: rtl/jfss_in_reg.sv
module jfss_in_reg
  import jfss_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  [7:0] in_data_byte,
  input  logic  in_last_in_stream,
  input  logic  down_free,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  item_t item_r;
  logic  take;

  // item moves on when the result side has room
  assign take     = valid_r && down_free;
  assign in_ready = !valid_r || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte      <= in_data_byte;
      item_r.last_in_stream <= in_last_in_stream;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/jfss_core.sv
module jfss_core
  import jfss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  hb_r, hb_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] seg_len;
  logic [7:0]  b;

  assign b       = item.data_byte;
  assign seg_len = {hb_r, b};

  // per-byte parser step
  always_comb begin
    phase_nxt  = phase_r;
    skip_nxt   = skip_r;
    hb_nxt     = hb_r;
    height_nxt = height_r;
    res_valid  = 1'b0;
    res        = '{image_width: 16'd0, image_height: 16'd0, status: ST_FOUND};
    case (phase_r)
      PH_SIG0: begin
        if (b != MARK_PREFIX) begin
          res_valid  = 1'b1;
          res.status = ST_BADSIG;
          phase_nxt  = PH_ABSORB;
        end else begin
          phase_nxt = PH_SIG1;
        end
      end
      PH_SIG1: begin
        if (b != SOI_ID) begin
          res_valid  = 1'b1;
          res.status = ST_BADSIG;
          phase_nxt  = PH_ABSORB;
        end else begin
          phase_nxt = PH_ID0;
        end
      end
      PH_ID0:    phase_nxt = PH_ID1;
      PH_ID1:    phase_nxt = PH_LEN_HI;
      PH_LEN_HI: begin
        hb_nxt    = b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len < LEN_MIN) begin
          res_valid  = 1'b1;
          res.status = ST_SHORT;
          phase_nxt  = PH_ABSORB;
        end else begin
          skip_nxt  = seg_len - LEN_MIN;
          phase_nxt = (seg_len == LEN_MIN) ? PH_MARK_FF : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          phase_nxt = PH_MARK_FF;
        end
      end
      PH_MARK_FF: begin
        if (b != MARK_PREFIX) begin
          res_valid  = 1'b1;
          res.status = ST_NOMARK;
          phase_nxt  = PH_ABSORB;
        end else begin
          phase_nxt = PH_MARK_ID;
        end
      end
      PH_MARK_ID: begin
        if (b == SOF0_ID) begin
          skip_nxt  = SOF_SKIP;
          phase_nxt = PH_SOF;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_SOF: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          phase_nxt = PH_H_HI;
        end
      end
      PH_H_HI: begin
        hb_nxt    = b;
        phase_nxt = PH_H_LO;
      end
      PH_H_LO: begin
        height_nxt = seg_len;
        phase_nxt  = PH_W_HI;
      end
      PH_W_HI: begin
        hb_nxt    = b;
        phase_nxt = PH_W_LO;
      end
      PH_W_LO: begin
        res_valid        = 1'b1;
        res.image_width  = seg_len;
        res.image_height = height_r;
        res.status       = ST_FOUND;
        phase_nxt        = PH_ABSORB;
      end
      PH_ABSORB: phase_nxt = PH_ABSORB;
      default:   phase_nxt = PH_ABSORB;
    endcase

    // end of file: report if nothing was given yet, then restart
    if (item.last_in_stream) begin
      if (!res_valid && (phase_r != PH_ABSORB)) begin
        res_valid  = 1'b1;
        res.status = ST_ENDED;
      end
      phase_nxt = PH_SIG0;
      skip_nxt  = 16'd0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG0;
      skip_r  <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // value holds
  always_ff @(posedge clk) begin
    if (step) begin
      hb_r     <= hb_nxt;
      height_r <= height_nxt;
    end
  end

endmodule

FILE: rtl/jfss_out_reg.sv
module jfss_out_reg
  import jfss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [2:0]  out_status
);

  logic    valid_r;
  result_t res_r;

  assign free = !valid_r || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_image_width  = res_r.image_width;
  assign out_image_height = res_r.image_height;
  assign out_status       = res_r.status;

endmodule

FILE: rtl/jpeg_frame_size_scanner_unit.sv
// jpeg frame size scanner: one file byte per item, at most one result per file
// path: the byte that causes a result passes the input register, the parser step and then the result register
// throughput: one byte per cycle while the result register is free, set by the combinational parser step between
//   the input register and the result register
// reset: synchronous active-low rst_n empties both registers and returns the
//   parser to the first signature byte
module jpeg_frame_size_scanner_unit
  import jfss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_in_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [2:0]  out_status
);

  logic    down_free;
  logic    item_valid;
  item_t   item;
  logic    step;
  logic    res_valid;
  result_t res;

  assign step = item_valid && down_free;

  // input register
  jfss_in_reg u_in (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_in_stream (in_last_in_stream),
    .down_free         (down_free),
    .item_valid        (item_valid),
    .item              (item)
  );

  // parser state machine
  jfss_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  jfss_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (step && res_valid),
    .res              (res),
    .free             (down_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_status       (out_status)
  );

endmodule

FILE: rtl/jfss_checker.sv
module jfss_checker
  import jfss_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_image_width,
  input logic [15:0] out_image_height,
  input logic [2:0]  out_status
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_image_width)
      && $stable(out_image_height) && $stable(out_status))
    else $error("stalled result changed");

  // input back-pressure only comes from a waiting result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no result waiting");

  // failures carry zero dimensions
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FOUND)
      |-> (out_image_width == 16'd0) && (out_image_height == 16'd0))
    else $error("failure result with nonzero size");

  // status is a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_FOUND) || (out_status == ST_BADSIG)
      || (out_status == ST_NOMARK) || (out_status == ST_ENDED)
      || (out_status == ST_SHORT))
    else $error("undefined status code");

endmodule

bind jpeg_frame_size_scanner_unit jfss_checker u_jfss_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_image_width  (out_image_width),
  .out_image_height (out_image_height),
  .out_status       (out_status)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import jfss_pkg::*;

  // parser steps of the local scanner copy
  typedef enum logic [3:0] {
    SC_SOI_FF, SC_SOI_D8, SC_APP_B0, SC_APP_B1, SC_LEN_HI, SC_LEN_LO, SC_BODY,
    SC_PREFIX, SC_MARKER, SC_SOF_HDR, SC_HGT_HI, SC_HGT_LO, SC_WID_HI, SC_WID_LO,
    SC_DONE
  } scan_phase_t;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_in_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_image_width;
  logic [15:0] out_image_height;
  logic [2:0]  out_status;

  // scanner state
  scan_phase_t scan_phase = SC_SOI_FF;
  logic [15:0] skip_left = '0;
  logic [7:0]  hi_byte = '0;
  logic [15:0] height_seen = '0;
  logic        size_given = 1'b0;

  result_t     pending_sizes[$];
  logic [7:0]  file_bytes[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          idle_run = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  jpeg_frame_size_scanner_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_in_stream (in_last_in_stream),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_image_width   (out_image_width),
    .out_image_height  (out_image_height),
    .out_status        (out_status)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // back to the first signature byte
  task automatic restart_scan();
    scan_phase  = SC_SOI_FF;
    skip_left   = '0;
    hi_byte     = '0;
    height_seen = '0;
    size_given  = 1'b0;
  endtask

  // advance the scanner by one byte, queue the size it reports
  task automatic scan_byte(input logic [7:0] b, input logic last);
    result_t     r;
    logic        have;
    logic [15:0] seg_len;
    r    = '0;
    have = 1'b0;
    case (scan_phase)
      SC_SOI_FF: begin
        if (b != MARK_PREFIX) begin
          have = 1'b1;
          r.status = ST_BADSIG;
        end else scan_phase = SC_SOI_D8;
      end
      SC_SOI_D8: begin
        if (b != SOI_ID) begin
          have = 1'b1;
          r.status = ST_BADSIG;
        end else scan_phase = SC_APP_B0;
      end
      SC_APP_B0: scan_phase = SC_APP_B1;
      SC_APP_B1: scan_phase = SC_LEN_HI;
      SC_LEN_HI: begin
        hi_byte = b;
        scan_phase = SC_LEN_LO;
      end
      SC_LEN_LO: begin
        seg_len = {hi_byte, b};
        if (seg_len < LEN_MIN) begin
          have = 1'b1;
          r.status = ST_SHORT;
        end else begin
          skip_left = seg_len - LEN_MIN;
          scan_phase = (skip_left == 0) ? SC_PREFIX : SC_BODY;
        end
      end
      SC_BODY: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) scan_phase = SC_PREFIX;
      end
      SC_PREFIX: begin
        if (b != MARK_PREFIX) begin
          have = 1'b1;
          r.status = ST_NOMARK;
        end else scan_phase = SC_MARKER;
      end
      SC_MARKER: begin
        if (b == SOF0_ID) begin
          skip_left = SOF_SKIP;
          scan_phase = SC_SOF_HDR;
        end else scan_phase = SC_LEN_HI;
      end
      SC_SOF_HDR: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) scan_phase = SC_HGT_HI;
      end
      SC_HGT_HI: begin
        hi_byte = b;
        scan_phase = SC_HGT_LO;
      end
      SC_HGT_LO: begin
        height_seen = {hi_byte, b};
        scan_phase = SC_WID_HI;
      end
      SC_WID_HI: begin
        hi_byte = b;
        scan_phase = SC_WID_LO;
      end
      SC_WID_LO: begin
        have = 1'b1;
        r.image_width  = {hi_byte, b};
        r.image_height = height_seen;
        r.status       = ST_FOUND;
      end
      default: scan_phase = SC_DONE;
    endcase
    if (have) begin
      size_given = 1'b1;
      scan_phase = SC_DONE;
    end
    // end of file: report a stream end if nothing was given yet
    if (last) begin
      if (!have && !size_given) begin
        have = 1'b1;
        r = '0;
        r.status = ST_ENDED;
      end
      restart_scan();
    end
    if (have) pending_sizes.push_back(r);
  endtask

  // predict on every accepted item
  always @(posedge clk) begin
    if (!rst_n) restart_scan();
    else if (in_valid && in_ready) scan_byte(in_data_byte, in_last_in_stream);
  end

  // compare each reported size with the oldest prediction
  always @(posedge clk) begin : size_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sizes.size() == 0) begin
        $error("result with none expected: width %0d height %0d status %0d",
               out_image_width, out_image_height, out_status);
        mismatches++;
      end else begin
        want = pending_sizes.pop_front();
        if (out_image_width !== want.image_width) begin
          $error("image_width: expected %0d, got %0d", want.image_width, out_image_width);
          mismatches++;
        end
        if (out_image_height !== want.image_height) begin
          $error("image_height: expected %0d, got %0d", want.image_height,
                 out_image_height);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(17, 1) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("[jpeg_frame_size_scanner_unit] ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // offer one item, with an occasional idle burst ahead of it
  task automatic put_byte(input logic [7:0] b, input logic last);
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(17, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_last_in_stream <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      put_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  // segment length and a body of random bytes
  task automatic add_segment(input logic [15:0] seg_len);
    file_bytes.push_back(seg_len[15:8]);
    file_bytes.push_back(seg_len[7:0]);
    for (int i = 2; i < seg_len; i++) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  function automatic logic [15:0] pick_len();
    if ($urandom_range(49) == 0) return 16'($urandom_range(300, 256));
    return 16'($urandom_range(9, 2));
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // well-formed file; bad_mark puts a wrong byte where the frame marker prefix goes
  task automatic build_jpeg(input int segs, input int tail, input bit bad_mark);
    logic [7:0]  mk;
    logic [15:0] h;
    logic [15:0] w;
    h = pick_dim();
    w = pick_dim();
    file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(SOI_ID);
    file_bytes.push_back(8'($urandom_range(255)));
    file_bytes.push_back(8'($urandom_range(255)));
    add_segment(pick_len());
    for (int s = 0; s < segs; s++) begin
      file_bytes.push_back(MARK_PREFIX);
      do mk = 8'($urandom_range(255)); while (mk == SOF0_ID);
      file_bytes.push_back(mk);
      add_segment(pick_len());
    end
    if (bad_mark) file_bytes.push_back(8'($urandom_range(254)));
    else file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(SOF0_ID);
    repeat (3) file_bytes.push_back(8'($urandom_range(255)));
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
    repeat (tail) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  // zero-length body, extreme sizes, one absorbed byte after the result
  task automatic test_found_extremes();
    file_bytes = {MARK_PREFIX, SOI_ID, 8'hAA, 8'h55, 8'h00, 8'h02, MARK_PREFIX, SOF0_ID,
                  8'h11, 8'h22, 8'h33, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h7E};
    send_file();
  endtask

  // wrong first byte, then wrong second byte, each also the last byte
  task automatic test_bad_signature();
    file_bytes = {8'hFE};
    send_file();
    file_bytes = {MARK_PREFIX, 8'hD7};
    send_file();
  endtask

  // segment length of one, given on the last byte
  task automatic test_short_length();
    file_bytes = {MARK_PREFIX, SOI_ID, 8'hE0, 8'h01, 8'h00, 8'h01};
    send_file();
  endtask

  // mostly well-formed files, some cut short, broken or pure noise
  task automatic test_random_streams(input int item_goal);
    int kind;
    int cut;
    while (items_sent < item_goal) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        build_jpeg($urandom_range(3), $urandom_range(4), 1'b0);
      end else if (kind < 67) begin
        build_jpeg($urandom_range(2), 0, 1'b0);
        cut = $urandom_range(file_bytes.size() - 1, 1);
        file_bytes = file_bytes[0:cut-1];
      end else if (kind < 77) begin
        build_jpeg($urandom_range(2), $urandom_range(3), 1'b1);
      end else if (kind < 84) begin
        build_jpeg($urandom_range(2), $urandom_range(3), 1'b0);
        file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom_range(255));
      end else if (kind < 90) begin
        file_bytes = {MARK_PREFIX, SOI_ID, 8'hE0, 8'h00, 8'h00, 8'($urandom_range(1))};
        repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(1)) file_bytes = {MARK_PREFIX, SOI_ID};
        repeat ($urandom_range(6, 1)) file_bytes.push_back(8'($urandom_range(255)));
      end
      send_file();
    end
  endtask

  // hold off the sender until every reported size is in
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sizes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // no idling on either side for the last stretch
  task automatic test_calm_tail();
    calm = 1'b1;
    test_random_streams(1050);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_found_extremes();
    test_bad_signature();
    test_short_length();
    test_random_streams(500);
    test_drain_pause();
    test_random_streams(900);
    test_calm_tail();
    // wait for the last results, then a short tail
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sizes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("[jpeg_frame_size_scanner_unit] OK");
    else $display("[jpeg_frame_size_scanner_unit] ERROR");
    $finish;
  end

endmodule
